### design/ppr_pkg.sv
// Package for the polar parameter ramp smoother: request codes, sequencer states, field widths
// and the saturation helper, imported by the block, its divider and its checker.
// No dependencies.
package ppr_pkg;

  localparam int SOURCES_DEFAULT = 16;
  localparam int MAX_RESULTS     = 32;

  localparam int VALUE_W    = 24;
  localparam int INDEX_W    = 5;
  localparam int REQ_W      = 3;
  localparam int RAD_W      = 40;
  localparam int AZI_W      = 32;
  localparam int ANGLE_W    = 16;
  localparam int FRAC_EXTRA = 16;
  localparam int DIVIDEND_W = 41;
  localparam int DIVISOR_W  = 16;
  localparam int QUOT_W     = 42;
  localparam int TDATA_W    = 32;

  localparam logic [DIVISOR_W-1:0] RAMP_LENGTH_RESET = 16'd4410;
  localparam logic signed [VALUE_W-1:0] RADIUS_ONE   = 24'sd65536;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK         = 3'd0,
    REQ_RAMP_RADIUS  = 3'd1,
    REQ_RAMP_AZIMUTH = 3'd2,
    REQ_SET_RADIUS   = 3'd3,
    REQ_SET_AZIMUTH  = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_DIV_START,
    ST_DIV_WAIT
  } state_t;

  // Saturates a wide signed value to the 40-bit radius range.
  function automatic logic signed [RAD_W-1:0] sat_rad(input logic signed [QUOT_W-1:0] v);
    logic signed [RAD_W-1:0] r;
    if (v[QUOT_W-1:RAD_W-1] == '0 || v[QUOT_W-1:RAD_W-1] == '1) begin
      r = v[RAD_W-1:0];
    end else if (v[QUOT_W-1]) begin
      r = {1'b1, {(RAD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(RAD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### design/ppr_div.sv
// Serial restoring divider for the ramp step: signed dividend by unsigned divisor,
// one quotient bit per cycle, quotient truncated toward zero.
// Depends on ppr_pkg.
module ppr_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [ppr_pkg::DIVIDEND_W-1:0] dividend,
  input  logic        [ppr_pkg::DIVISOR_W-1:0]  divisor,
  output logic                                 done,
  output logic signed [ppr_pkg::QUOT_W-1:0]     quotient
);
  import ppr_pkg::*;

  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic [CW-1:0]         count;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic                  neg;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;
  logic [DIVISOR_W-1:0]  rem_next;
  logic [QUOT_W-1:0]     mag;

  assign trial    = {rem, quo[DIVIDEND_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign diff     = trial - {1'b0, dvs};
  assign rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
  assign mag      = {1'b0, quo};
  assign quotient = neg ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(DIVIDEND_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      neg <= dividend[DIVIDEND_W-1];
      quo <= dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

endmodule

### design/polar_parameter_ramp_smoother.sv
// Top level of the polar parameter ramp smoother: parameter storage, request sequencer,
// tick walk and output register. Depends on ppr_pkg and ppr_div.
// Tick: one entry per cycle over 2*SOURCES entries (32 at 16 sources), unless the output holds a waiting result.
// Ramp request: the step comes from the 41-step serial divider. Direct set: written when accepted.
// The next item is taken once the current one is done; a result may still wait in the output.
// Synchronous reset restores radius 1.0, azimuth 0, zero steps and counter, ramp length 4410.
module polar_parameter_ramp_smoother #(
  parameter int SOURCES = ppr_pkg::SOURCES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [ppr_pkg::DIVISOR_W-1:0]     cfg_wr_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ppr_pkg::TDATA_W-1:0]       s_axis_tdata,  // source_index, value
  input  logic [ppr_pkg::REQ_W-1:0]         s_axis_tuser,  // req_type
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ppr_pkg::TDATA_W-1:0]       m_axis_tdata,  // source_index_res, smoothed_value
  output logic                              m_axis_tuser,  // is_azimuth
  output logic                              m_axis_tlast
);
  import ppr_pkg::*;

  localparam int IW      = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int ENTRIES = 2 * SOURCES;
  localparam int JW      = $clog2(ENTRIES);
  localparam int NOUT    = (ENTRIES < MAX_RESULTS) ? ENTRIES : MAX_RESULTS;

  state_t state;
  state_t state_next;

  logic [DIVISOR_W-1:0] ramp_length;
  logic [DIVISOR_W-1:0] ramp_counter;

  logic signed [RAD_W-1:0]   rad_cur  [SOURCES];
  logic signed [VALUE_W-1:0] rad_tgt  [SOURCES];
  logic signed [RAD_W-1:0]   rad_step [SOURCES];
  logic [AZI_W-1:0]          azi_cur  [SOURCES];
  logic [ANGLE_W-1:0]        azi_tgt  [SOURCES];
  logic [AZI_W-1:0]          azi_step [SOURCES];

  logic [JW-1:0]             entry;
  logic                      r_az;
  logic [IW-1:0]             r_idx;
  logic signed [VALUE_W-1:0] r_val;

  req_t                      in_req;
  logic [INDEX_W-1:0]        in_idx;
  logic signed [VALUE_W-1:0] in_val;
  logic                      in_ok;
  logic                      accept;

  logic                      snap;
  logic                      tick_az;
  logic [JW-1:0]             src_full;
  logic [IW-1:0]             src;
  logic signed [DIVIDEND_W-1:0] rad_sum;
  logic signed [RAD_W-1:0]   rad_new;
  logic [AZI_W-1:0]          azi_new;
  logic                      emit;
  logic                      is_last;
  logic                      out_free;
  logic                      tick_go;
  logic                      tick_end;
  logic [VALUE_W-1:0]        out_value;

  logic signed [DIVIDEND_W-1:0] rad_d;
  logic signed [AZI_W+1:0]      azi_d0;
  logic signed [AZI_W+1:0]      azi_d;
  logic signed [DIVIDEND_W-1:0] dividend;
  logic                         div_start;
  logic                         div_done;
  logic signed [QUOT_W-1:0]     quotient;

  ppr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (ramp_length),
    .done     (div_done),
    .quotient (quotient)
  );

  assign in_req = req_t'(s_axis_tuser);
  assign in_idx = s_axis_tdata[INDEX_W-1:0];
  assign in_val = s_axis_tdata[INDEX_W+VALUE_W-1:INDEX_W];
  assign in_ok  = {1'b0, in_idx} < (INDEX_W+1)'(SOURCES);
  assign accept = s_axis_tvalid && s_axis_tready;

  assign snap     = ramp_counter >= ramp_length;
  assign tick_az  = entry >= JW'(SOURCES);
  assign src_full = tick_az ? entry - JW'(SOURCES) : entry;
  assign src      = src_full[IW-1:0];
  assign rad_sum  = {rad_cur[src][RAD_W-1], rad_cur[src]}
                  + {rad_step[src][RAD_W-1], rad_step[src]};
  assign rad_new  = snap ? {rad_tgt[src], {FRAC_EXTRA{1'b0}}}
                         : sat_rad(QUOT_W'(rad_sum));
  assign azi_new  = snap ? {azi_tgt[src], {FRAC_EXTRA{1'b0}}} : azi_cur[src] + azi_step[src];
  assign emit     = {1'b0, entry} < (JW+1)'(NOUT);
  assign is_last  = {1'b0, entry} == (JW+1)'(NOUT - 1);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign tick_go  = (state == ST_TICK) && (!emit || out_free);
  assign tick_end = tick_go && (entry == JW'(ENTRIES - 1));
  assign out_value = tick_az ? {{(VALUE_W-ANGLE_W){1'b0}}, azi_new[AZI_W-1:AZI_W-ANGLE_W]}
                             : rad_new[RAD_W-1:FRAC_EXTRA];

  // The azimuth ramp takes the shorter way round unless the distance is exactly half a turn.
  always_comb begin
    rad_d  = {r_val[VALUE_W-1], r_val, {FRAC_EXTRA{1'b0}}}
           - {rad_cur[r_idx][RAD_W-1], rad_cur[r_idx]};
    azi_d0 = {2'b00, r_val[ANGLE_W-1:0], {FRAC_EXTRA{1'b0}}} - {2'b00, azi_cur[r_idx]};
    if (azi_d0 > (AZI_W+2)'(64'sh8000_0000)) begin
      azi_d = azi_d0 - (AZI_W+2)'(64'sh1_0000_0000);
    end else if (azi_d0 < -(AZI_W+2)'(64'sh8000_0000)) begin
      azi_d = azi_d0 + (AZI_W+2)'(64'sh1_0000_0000);
    end else begin
      azi_d = azi_d0;
    end
    dividend = r_az ? DIVIDEND_W'(azi_d) : rad_d;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_req == REQ_TICK) begin
            state_next = ST_TICK;
          end else if ((in_req == REQ_RAMP_RADIUS || in_req == REQ_RAMP_AZIMUTH) && in_ok) begin
            state_next = ST_DIV_START;
          end
        end
      end
      ST_TICK: begin
        if (tick_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV_START: begin
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    div_start     = (state == ST_DIV_START);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      ramp_length <= RAMP_LENGTH_RESET;
      entry       <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        ramp_length <= (cfg_wr_data == '0) ? DIVISOR_W'(1) : cfg_wr_data;
      end
      if (tick_go) begin
        entry <= tick_end ? '0 : entry + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_az  <= (in_req == REQ_RAMP_AZIMUTH);
      r_idx <= in_idx[IW-1:0];
      r_val <= in_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_counter <= '0;
      for (int k = 0; k < SOURCES; k++) begin
        rad_cur[k]  <= {RADIUS_ONE, {FRAC_EXTRA{1'b0}}};
        rad_tgt[k]  <= RADIUS_ONE;
        rad_step[k] <= '0;
        azi_cur[k]  <= '0;
        azi_tgt[k]  <= '0;
        azi_step[k] <= '0;
      end
    end else begin
      if (state == ST_IDLE && accept && in_ok) begin
        unique case (in_req)
          REQ_SET_RADIUS: begin
            rad_tgt[in_idx[IW-1:0]]  <= in_val;
            rad_cur[in_idx[IW-1:0]]  <= {in_val, {FRAC_EXTRA{1'b0}}};
            rad_step[in_idx[IW-1:0]] <= '0;
            ramp_counter             <= '0;
          end
          REQ_SET_AZIMUTH: begin
            azi_tgt[in_idx[IW-1:0]]  <= in_val[ANGLE_W-1:0];
            azi_cur[in_idx[IW-1:0]]  <= {in_val[ANGLE_W-1:0], {FRAC_EXTRA{1'b0}}};
            azi_step[in_idx[IW-1:0]] <= '0;
            ramp_counter             <= '0;
          end
          default: begin
          end
        endcase
      end
      if (state == ST_DIV_WAIT && div_done) begin
        ramp_counter <= '0;
        if (r_az) begin
          azi_tgt[r_idx]  <= r_val[ANGLE_W-1:0];
          azi_step[r_idx] <= quotient[AZI_W-1:0];
        end else begin
          rad_tgt[r_idx]  <= r_val;
          rad_step[r_idx] <= sat_rad(quotient);
        end
      end
      if (tick_go) begin
        if (tick_az) begin
          azi_cur[src] <= azi_new;
          if (snap) begin
            azi_step[src] <= '0;
          end
        end else begin
          rad_cur[src] <= rad_new;
          if (snap) begin
            rad_step[src] <= '0;
          end
        end
        if (tick_end) begin
          ramp_counter <= snap ? '0 : ramp_counter + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (tick_go && emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go && emit) begin
      m_axis_tdata <= {{(TDATA_W-INDEX_W-VALUE_W){1'b0}}, out_value, INDEX_W'(src_full)};
      m_axis_tuser <= tick_az;
      m_axis_tlast <= is_last;
    end
  end

endmodule

### design/ppr_chk.sv
// Port-level checker for the polar parameter ramp smoother, bound to the top level.
// Depends on ppr_pkg and polar_parameter_ramp_smoother.
module ppr_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [ppr_pkg::TDATA_W-1:0]   s_axis_tdata,
  input logic [ppr_pkg::REQ_W-1:0]     s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ppr_pkg::TDATA_W-1:0]   m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          m_axis_tlast
);
  import ppr_pkg::*;

  // An accepted tick keeps the block busy on the following cycle.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_TICK |=> !s_axis_tready)
    else $error("input accepted right after a tick transaction");

  // Only a tick produces results, so no other request starts a new result.
  a_set_silent: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser != REQ_TICK |=> !$rose(m_axis_tvalid))
    else $error("result appeared after a set transaction");

  // The last result of a tick is always an azimuth when SOURCES is below 32.
  a_last_azimuth: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("tick ended on a radius result");

  // An azimuth result is a 16-bit angle.
  a_azimuth_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[TDATA_W-1:INDEX_W+ANGLE_W] == '0)
    else $error("azimuth result exceeds one turn");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind polar_parameter_ramp_smoother ppr_chk u_ppr_chk (.*);

### test/polar_parameter_ramp_smoother_test.sv
// Self-checking testbench for polar_parameter_ramp_smoother: a directed table, then random
// ramp, set, tick and invalid requests over several ramp lengths, each checked against a local model.
// Depends on ppr_pkg and the design files.
module polar_parameter_ramp_smoother_test;
  import ppr_pkg::*;

  localparam int NSRC = SOURCES_DEFAULT;
  localparam int NRES = (2 * NSRC < MAX_RESULTS) ? 2 * NSRC : MAX_RESULTS;
  localparam int DIRECTED_ROWS = 25;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 60;
  localparam longint RAD_MAX = 64'sd549755813887;
  localparam longint RAD_MIN = -RAD_MAX - 64'sd1;
  localparam longint HALF_TURN = 64'sd2147483648;
  localparam longint FULL_TURN = 64'sd4294967296;
  localparam logic [REQ_W-1:0] REQ_BAD_LO  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_BAD_MID = 3'd6;
  localparam logic [REQ_W-1:0] REQ_BAD_HI  = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0]          req;
    logic [INDEX_W-1:0]        idx;
    logic signed [VALUE_W-1:0] value;
  } request_t;

  typedef struct {
    logic [REQ_W-1:0]          req;
    logic [INDEX_W-1:0]        idx;
    logic signed [VALUE_W-1:0] value;
    bit                        pinned;
    logic signed [VALUE_W-1:0] pin_radius;
    logic [ANGLE_W-1:0]        pin_angle;
  } directed_row_t;

  typedef struct {
    logic [INDEX_W-1:0]        src;
    logic                      az;
    logic signed [VALUE_W-1:0] val;
    logic                      last;
  } smoothed_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [DIVISOR_W-1:0] cfg_wr_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;
  logic [REQ_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  logic signed [RAD_W-1:0]   cur_radius [NSRC];
  logic signed [VALUE_W-1:0] goal_radius [NSRC];
  logic signed [RAD_W-1:0]   radius_step [NSRC];
  logic [AZI_W-1:0]          cur_angle [NSRC];
  logic [ANGLE_W-1:0]        goal_angle [NSRC];
  logic signed [AZI_W:0]     angle_step [NSRC];
  logic [DIVISOR_W-1:0]      shared_count;
  logic [DIVISOR_W-1:0]      ramp_len;

  smoothed_t tick_out [NRES];
  smoothed_t pending_smoothed [$];
  int fails = 0;
  bit quiet = 1'b0;
  bit press_go = 1'b0;
  bit press_done = 1'b0;
  int hold_left = 0;
  int stall_left = 0;

  polar_parameter_ramp_smoother dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [RAD_W-1:0] clamp40(input longint v);
    longint c;
    c = v;
    if (c > RAD_MAX) begin
      c = RAD_MAX;
    end else if (c < RAD_MIN) begin
      c = RAD_MIN;
    end
    return c[RAD_W-1:0];
  endfunction

  // Advances the local copy of the parameter state by one request and fills tick_out.
  function automatic int smooth_request(input logic [REQ_W-1:0] req,
                                        input logic [INDEX_W-1:0] idx,
                                        input logic signed [VALUE_W-1:0] value);
    longint d;
    longint span;
    longint nw;
    longint od;
    int s;
    int n;
    n = 0;
    if (req == REQ_TICK) begin
      for (int i = 0; i < NSRC; i++) begin
        cur_radius[i] = clamp40(longint'(cur_radius[i]) + longint'(radius_step[i]));
        cur_angle[i] = cur_angle[i] + angle_step[i][AZI_W-1:0];
      end
      if (shared_count >= ramp_len) begin
        for (int i = 0; i < NSRC; i++) begin
          cur_radius[i] = {goal_radius[i], 16'h0000};
          cur_angle[i] = {goal_angle[i], 16'h0000};
          radius_step[i] = '0;
          angle_step[i] = '0;
        end
        shared_count = '0;
      end else begin
        shared_count = shared_count + 16'd1;
      end
      for (int k = 0; k < NRES; k++) begin
        s = (k < NSRC) ? k : k - NSRC;
        tick_out[k].src = INDEX_W'(s);
        tick_out[k].az = (k >= NSRC);
        tick_out[k].val = (k >= NSRC) ? {8'h00, cur_angle[s][AZI_W-1:FRAC_EXTRA]}
                                      : cur_radius[s][RAD_W-1:FRAC_EXTRA];
        tick_out[k].last = (k == NRES - 1);
        n++;
      end
    end else if (req <= REQ_SET_AZIMUTH && idx < NSRC) begin
      shared_count = '0;
      case (req)
        REQ_RAMP_RADIUS: begin
          d = longint'(value) * 64'sd65536 - longint'(cur_radius[idx]);
          goal_radius[idx] = value;
          radius_step[idx] = clamp40(d / longint'(ramp_len));
        end
        REQ_RAMP_AZIMUTH: begin
          nw = longint'({value[ANGLE_W-1:0], 16'h0000});
          od = longint'(cur_angle[idx]);
          d = nw - od;
          span = (d < 0) ? -d : d;
          if (span > HALF_TURN) begin
            d = (nw > od) ? d - FULL_TURN : d + FULL_TURN;
          end
          goal_angle[idx] = value[ANGLE_W-1:0];
          angle_step[idx] = 33'(d / longint'(ramp_len));
        end
        REQ_SET_RADIUS: begin
          goal_radius[idx] = value;
          cur_radius[idx] = {value, 16'h0000};
          radius_step[idx] = '0;
        end
        default: begin
          goal_angle[idx] = value[ANGLE_W-1:0];
          cur_angle[idx] = {value[ANGLE_W-1:0], 16'h0000};
          angle_step[idx] = '0;
        end
      endcase
    end
    return n;
  endfunction

  function automatic request_t random_request();
    request_t rq;
    int pick;
    pick = $urandom_range(0, 99);
    rq.idx = INDEX_W'($urandom_range(0, NSRC - 1));
    rq.value = VALUE_W'($urandom);
    case ($urandom_range(0, 7))
      0: rq.value = 24'h7FFFFF;
      1: rq.value = 24'h800000;
      2: rq.value = 24'h000000;
      3: rq.value = 24'hFFFFFF;
      default: ;
    endcase
    if (pick < 35) begin
      rq.req = REQ_TICK;
      rq.idx = INDEX_W'($urandom);
    end else if (pick < 57) begin
      rq.req = REQ_RAMP_RADIUS;
    end else if (pick < 79) begin
      rq.req = REQ_RAMP_AZIMUTH;
      if ($urandom_range(0, 5) == 0) begin
        rq.value[ANGLE_W-1:0] = cur_angle[rq.idx][AZI_W-1:FRAC_EXTRA] ^ 16'h8000;
      end
    end else if (pick < 86) begin
      rq.req = REQ_SET_RADIUS;
    end else if (pick < 93) begin
      rq.req = REQ_SET_AZIMUTH;
    end else if (pick < 96) begin
      rq.req = REQ_W'($urandom_range(REQ_RAMP_RADIUS, REQ_SET_AZIMUTH));
      rq.idx = INDEX_W'($urandom_range(NSRC, 31));
    end else begin
      rq.req = REQ_W'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
      rq.idx = INDEX_W'($urandom);
    end
    return rq;
  endfunction

  // Returns at the rising edge where the input transaction is taken.
  task automatic offer(input request_t rq, output int n);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = rq.req;
    s_axis_tdata = TDATA_W'({rq.value, rq.idx});
    do @(posedge clk); while (!s_axis_tready);
    n = smooth_request(rq.req, rq.idx, rq.value);
  endtask

  task automatic push_results(input int n);
    for (int k = 0; k < n; k++) begin
      pending_smoothed.push_back(tick_out[k]);
    end
  endtask

  task automatic settle();
    int w;
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    for (w = 0; w < 50000 && pending_smoothed.size() != 0; w++) begin
      @(negedge clk);
    end
    repeat (100) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left = hold_left - 1;
    end else if (press_go && !press_done) begin
      press_done = 1'b1;
      hold_left = 400;
      m_axis_tready = 1'b0;
    end else if (stall_left > 0) begin
      m_axis_tready = 1'b0;
      stall_left = stall_left - 1;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 4);
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    smoothed_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_smoothed.size() == 0) begin
        $error("unexpected result transaction: source_index_res %0d",
               m_axis_tdata[INDEX_W-1:0]);
        fails++;
      end else begin
        want = pending_smoothed.pop_front();
        if (m_axis_tdata[INDEX_W-1:0] !== want.src) begin
          $error("source_index_res: expected %0d, got %0d", want.src,
                 m_axis_tdata[INDEX_W-1:0]);
          fails++;
        end
        if (m_axis_tuser !== want.az) begin
          $error("is_azimuth: expected %0d, got %0d", want.az, m_axis_tuser);
          fails++;
        end
        if (m_axis_tdata[INDEX_W +: VALUE_W] !== want.val) begin
          $error("smoothed_value: expected %0d, got %0d", want.val,
                 $signed(m_axis_tdata[INDEX_W +: VALUE_W]));
          fails++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
          fails++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("polar_parameter_ramp_smoother_test: done, errors");
    $finish;
  end

  initial begin
    directed_row_t script [DIRECTED_ROWS];
    logic [DIVISOR_W-1:0] lengths [PHASES];
    request_t rq;
    int n;
    script = '{
      '{REQ_TICK,         5'd0,  24'h000000, 1'b1, 24'h010000, 16'h0000},
      '{REQ_SET_RADIUS,   5'd0,  24'h7FFFFF, 1'b0, 24'h000000, 16'h0000},
      '{REQ_SET_RADIUS,   5'd1,  24'h800000, 1'b0, 24'h000000, 16'h0000},
      '{REQ_SET_AZIMUTH,  5'd2,  24'h00FFFF, 1'b0, 24'h000000, 16'h0000},
      '{REQ_SET_AZIMUTH,  5'd3,  24'h7F0001, 1'b0, 24'h000000, 16'h0000},
      '{REQ_TICK,         5'd0,  24'h000000, 1'b1, 24'h7FFFFF, 16'h0000},
      '{REQ_TICK,         5'd1,  24'h000000, 1'b1, 24'h800000, 16'h0000},
      '{REQ_TICK,         5'd2,  24'h000000, 1'b1, 24'h010000, 16'hFFFF},
      '{REQ_TICK,         5'd3,  24'h000000, 1'b1, 24'h010000, 16'h0001},
      '{REQ_RAMP_RADIUS,  5'd4,  24'h7FFFFF, 1'b0, 24'h000000, 16'h0000},
      '{REQ_RAMP_RADIUS,  5'd5,  24'h800000, 1'b0, 24'h000000, 16'h0000},
      '{REQ_RAMP_AZIMUTH, 5'd6,  24'h008000, 1'b0, 24'h000000, 16'h0000},
      '{REQ_RAMP_AZIMUTH, 5'd7,  24'h00C000, 1'b0, 24'h000000, 16'h0000},
      '{REQ_RAMP_AZIMUTH, 5'd2,  24'h800001, 1'b0, 24'h000000, 16'h0000},
      '{REQ_RAMP_RADIUS,  5'd16, 24'h000000, 1'b0, 24'h000000, 16'h0000},
      '{REQ_RAMP_AZIMUTH, 5'd31, 24'hFFFFFF, 1'b0, 24'h000000, 16'h0000},
      '{REQ_BAD_LO,       5'd0,  24'h000000, 1'b0, 24'h000000, 16'h0000},
      '{REQ_BAD_MID,      5'd9,  24'h123456, 1'b0, 24'h000000, 16'h0000},
      '{REQ_BAD_HI,       5'd31, 24'hFFFFFF, 1'b0, 24'h000000, 16'h0000},
      '{REQ_TICK,         5'd0,  24'h000000, 1'b0, 24'h000000, 16'h0000},
      '{REQ_TICK,         5'd31, 24'hFFFFFF, 1'b0, 24'h000000, 16'h0000},
      '{REQ_SET_RADIUS,   5'd15, 24'h000000, 1'b0, 24'h000000, 16'h0000},
      '{REQ_SET_AZIMUTH,  5'd15, 24'hFFFFFF, 1'b0, 24'h000000, 16'h0000},
      '{REQ_TICK,         5'd15, 24'h000000, 1'b1, 24'h000000, 16'hFFFF},
      '{REQ_TICK,         5'd0,  24'h000000, 1'b0, 24'h000000, 16'h0000}
    };
    lengths = '{16'd0, 16'hFFFF, 16'd1, 16'd2, 16'd3, 16'd1, 16'd5, 16'd1};
    lengths[4] = DIVISOR_W'($urandom_range(3, 12));
    lengths[6] = DIVISOR_W'($urandom_range(2, 40));
    lengths[7] = DIVISOR_W'($urandom_range(1, 6));

    for (int i = 0; i < NSRC; i++) begin
      goal_radius[i] = RADIUS_ONE;
      cur_radius[i] = {RADIUS_ONE, 16'h0000};
      radius_step[i] = '0;
      cur_angle[i] = '0;
      goal_angle[i] = '0;
      angle_step[i] = '0;
    end
    shared_count = '0;
    ramp_len = RAMP_LENGTH_RESET;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Pinned rows replace the computed values of their source with the typed ones.
    foreach (script[r]) begin
      rq = '{script[r].req, script[r].idx, script[r].value};
      offer(rq, n);
      if (script[r].pinned) begin
        tick_out[script[r].idx].val = script[r].pin_radius;
        tick_out[NSRC + script[r].idx].val = {8'h00, script[r].pin_angle};
      end
      push_results(n);
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      @(negedge clk);
      cfg_wr_en = 1'b1;
      cfg_wr_data = lengths[p];
      @(negedge clk);
      cfg_wr_en = 1'b0;
      ramp_len = (lengths[p] == '0) ? 16'd1 : lengths[p];
      quiet = (p == PHASES - 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        rq = random_request();
        // The long output hold starts here; ticks keep the block busy so its input backs up.
        if (p == 3 && k >= 5 && k < 9) begin
          press_go = 1'b1;
          rq.req = REQ_TICK;
        end
        offer(rq, n);
        push_results(n);
      end
    end

    settle();
    if (pending_smoothed.size() != 0) begin
      $error("%0d expected results never arrived", pending_smoothed.size());
      fails++;
    end
    if (fails == 0) begin
      $display("polar_parameter_ramp_smoother_test: done, clean");
    end else begin
      $display("polar_parameter_ramp_smoother_test: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
design/ppr_pkg.sv
design/ppr_div.sv
design/polar_parameter_ramp_smoother.sv
design/ppr_chk.sv
test/polar_parameter_ramp_smoother_test.sv
